// File: rtl/core/rcjv_pkg.sv
// Shared types, defaults and helpers for the rank correlation jackknife block.
// No dependencies.
package rcjv_pkg;

    localparam int MAX_PAIRS_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int IDX_W         = 6;
    localparam int Q_W           = 34;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RK_LATCH,
        OP_RK_ACC,
        OP_RK_WR,
        OP_SUM_ACC,
        OP_DEN,
        OP_RAT_GO,
        OP_RAT_ST,
        OP_IN_LATCH,
        OP_IN_ACC,
        OP_IN_P1,
        OP_IN_P2,
        OP_IN_P3,
        OP_IN_P4,
        OP_IN_GO,
        OP_IN_ST,
        OP_IN_SQ,
        OP_VAR_GO,
        OP_VAR_ST,
        OP_OUT_LD
    } t_op;

    typedef struct packed {
        logic degen;
        logic div_done;
    } t_sts;

    function automatic int maxi(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// File: rtl/core/rcjv_if.sv
// Valid/ready channel interfaces for sample beats and result beats.
// Depends on rcjv_pkg.
interface rcjv_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [rcjv_pkg::DATA_W-1:0]  x_sample;
    logic signed [rcjv_pkg::DATA_W-1:0]  y_sample;
    logic                                last_pair;

    modport source (output valid, x_sample, y_sample, last_pair, input ready);
    modport sink   (input valid, x_sample, y_sample, last_pair, output ready);
endinterface

interface rcjv_out_if;
    logic                                valid;
    logic                                ready;
    logic        [rcjv_pkg::IDX_W-1:0]   pair_index;
    logic signed [rcjv_pkg::DATA_W-1:0]  influence;
    logic signed [rcjv_pkg::DATA_W-1:0]  ratio;
    logic        [rcjv_pkg::DATA_W-1:0]  variance;
    logic                                degenerate;
    logic                                last_result;

    modport source (output valid, pair_index, influence, ratio, variance, degenerate,
                    last_result, input ready);
    modport sink   (input valid, pair_index, influence, ratio, variance, degenerate,
                    last_result, output ready);
endinterface

// File: rtl/core/rcjv_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module rcjv_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// File: rtl/core/rcjv_div.sv
// Restoring divider, one quotient bit per cycle, result round(num/den) capped.
// Depends on rcjv_pkg.
module rcjv_div #(
    parameter int W = 81
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [W-1:0]             i_num,
    input  logic [W-1:0]             i_den,
    output logic                     o_done,
    output logic [rcjv_pkg::Q_W-1:0] o_q
);
    localparam int QW = rcjv_pkg::Q_W;

    logic          r_busy;
    logic          r_done;
    logic [5:0]    r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_dsh;
    logic [QW-1:0] r_q;
    logic [QW-1:0] r_res;
    logic          ge;
    logic [QW-1:0] q_nx;
    logic [QW:0]   rnd;

    always_comb begin
        ge   = (r_rem >= r_dsh);
        q_nx = {r_q[QW-2:0], ge};
        rnd  = (QW+1)'(q_nx) + (QW+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= {i_num[W-2:0], 1'b0};
                r_dsh  <= i_den << QW;
                r_cnt  <= 6'(QW);
                r_q    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt == 6'(QW)) begin
                    if (ge) begin
                        r_res  <= QW'(1) << (QW - 1);
                        r_done <= 1'b1;
                        r_busy <= 1'b0;
                    end else begin
                        r_dsh <= r_dsh >> 1;
                        r_cnt <= r_cnt - 6'd1;
                    end
                end else begin
                    if (ge) begin
                        r_rem <= r_rem - r_dsh;
                    end
                    r_q   <= q_nx;
                    r_dsh <= r_dsh >> 1;
                    if (r_cnt == 6'd0) begin
                        r_res  <= rnd[QW:1];
                        r_done <= 1'b1;
                        r_busy <= 1'b0;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_res;
endmodule

// File: rtl/core/rcjv_ctrl.sv
// Sequencer: load, rank sweep, sums, ratio, influence sweep, variance, output.
// Depends on rcjv_pkg.
module rcjv_ctrl #(
    parameter int MAX_PAIRS = rcjv_pkg::MAX_PAIRS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_last,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  rcjv_pkg::t_sts                 i_sts,
    output rcjv_pkg::t_op                  o_op,
    output logic [$clog2(MAX_PAIRS)-1:0]   o_raddr,
    output logic [$clog2(MAX_PAIRS)-1:0]   o_waddr,
    output logic [$clog2(MAX_PAIRS+1)-1:0] o_idx,
    output logic [$clog2(MAX_PAIRS+1)-1:0] o_n
);
    localparam int CW  = $clog2(MAX_PAIRS + 1);
    localparam int ADW = $clog2(MAX_PAIRS);

    typedef enum logic [4:0] {
        S_LOAD, S_RK_I, S_RK_L, S_RK_J, S_RK_W, S_RK_WR, S_SUM, S_SUM_W, S_DEN, S_DEN_W,
        S_RAT_GO, S_RAT_WT, S_IN_I, S_IN_L, S_IN_J, S_IN_W, S_IN_P1, S_IN_P2, S_IN_P3,
        S_IN_P4, S_IN_GO, S_IN_WT, S_IN_SQ, S_VAR_GO, S_VAR_WT, S_OUT_RD, S_OUT_LD, S_OUT_W
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_i, n_i;
    logic [CW-1:0]   r_j, n_j;
    logic            r_out_valid, n_out_valid;
    logic [CW-1:0]   nm1;
    logic            room;
    rcjv_pkg::t_op   op;

    always_comb begin
        nm1         = r_cnt - CW'(1);
        room        = (r_cnt < CW'(MAX_PAIRS));
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_i         = r_i;
        n_j         = r_j;
        n_out_valid = r_out_valid;
        op          = rcjv_pkg::OP_NONE;
        o_raddr     = r_i[ADW-1:0];
        o_waddr     = r_i[ADW-1:0];
        case (r_state)
            S_LOAD: begin
                o_waddr = r_cnt[ADW-1:0];
                if (i_in_valid) begin
                    if (room) begin
                        op    = rcjv_pkg::OP_LOAD;
                        n_cnt = r_cnt + CW'(1);
                    end
                    if (i_last) begin
                        n_i     = '0;
                        n_state = S_RK_I;
                    end
                end
            end
            S_RK_I: n_state = S_RK_L;
            S_RK_L: begin
                op      = rcjv_pkg::OP_RK_LATCH;
                n_j     = '0;
                n_state = S_RK_J;
            end
            S_RK_J: begin
                o_raddr = r_j[ADW-1:0];
                op      = rcjv_pkg::OP_RK_ACC;
                n_j     = r_j + CW'(1);
                if (r_j == nm1) n_state = S_RK_W;
            end
            S_RK_W: n_state = S_RK_WR;
            S_RK_WR: begin
                op  = rcjv_pkg::OP_RK_WR;
                n_i = r_i + CW'(1);
                if (r_i == nm1) begin
                    n_j     = '0;
                    n_state = S_SUM;
                end else begin
                    n_state = S_RK_I;
                end
            end
            S_SUM: begin
                o_raddr = r_j[ADW-1:0];
                op      = rcjv_pkg::OP_SUM_ACC;
                n_j     = r_j + CW'(1);
                if (r_j == nm1) n_state = S_SUM_W;
            end
            S_SUM_W: n_state = S_DEN;
            S_DEN: begin
                op      = rcjv_pkg::OP_DEN;
                n_state = S_DEN_W;
            end
            S_DEN_W: begin
                n_i     = '0;
                n_state = i_sts.degen ? S_OUT_RD : S_RAT_GO;
            end
            S_RAT_GO: begin
                op      = rcjv_pkg::OP_RAT_GO;
                n_state = S_RAT_WT;
            end
            S_RAT_WT: begin
                if (i_sts.div_done) begin
                    op      = rcjv_pkg::OP_RAT_ST;
                    n_i     = '0;
                    n_state = S_IN_I;
                end
            end
            S_IN_I: n_state = S_IN_L;
            S_IN_L: begin
                op      = rcjv_pkg::OP_IN_LATCH;
                n_j     = '0;
                n_state = S_IN_J;
            end
            S_IN_J: begin
                o_raddr = r_j[ADW-1:0];
                op      = rcjv_pkg::OP_IN_ACC;
                n_j     = r_j + CW'(1);
                if (r_j == nm1) n_state = S_IN_W;
            end
            S_IN_W:  n_state = S_IN_P1;
            S_IN_P1: begin
                op      = rcjv_pkg::OP_IN_P1;
                n_state = S_IN_P2;
            end
            S_IN_P2: begin
                op      = rcjv_pkg::OP_IN_P2;
                n_state = S_IN_P3;
            end
            S_IN_P3: begin
                op      = rcjv_pkg::OP_IN_P3;
                n_state = S_IN_P4;
            end
            S_IN_P4: begin
                op      = rcjv_pkg::OP_IN_P4;
                n_state = S_IN_GO;
            end
            S_IN_GO: begin
                op      = rcjv_pkg::OP_IN_GO;
                n_state = S_IN_WT;
            end
            S_IN_WT: begin
                if (i_sts.div_done) begin
                    op      = rcjv_pkg::OP_IN_ST;
                    n_state = S_IN_SQ;
                end
            end
            S_IN_SQ: begin
                op  = rcjv_pkg::OP_IN_SQ;
                n_i = r_i + CW'(1);
                n_state = (r_i == nm1) ? S_VAR_GO : S_IN_I;
            end
            S_VAR_GO: begin
                op      = rcjv_pkg::OP_VAR_GO;
                n_state = S_VAR_WT;
            end
            S_VAR_WT: begin
                if (i_sts.div_done) begin
                    op      = rcjv_pkg::OP_VAR_ST;
                    n_i     = '0;
                    n_state = S_OUT_RD;
                end
            end
            S_OUT_RD: n_state = S_OUT_LD;
            S_OUT_LD: begin
                op          = rcjv_pkg::OP_OUT_LD;
                n_out_valid = 1'b1;
                n_state     = S_OUT_W;
            end
            S_OUT_W: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_i         = r_i + CW'(1);
                    if (r_i == nm1) begin
                        n_cnt   = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_i         <= n_i;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_op        = op;
    assign o_idx       = r_i;
    assign o_n         = r_cnt;

    a_valid_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_state == S_OUT_W)
        else $error("result valid outside output wait");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_PAIRS))
        else $error("pair count above capacity");

    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && i_in_valid && i_last) |=> (r_state == S_RK_I && r_i == '0))
        else $error("last beat did not start ranking");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT_W && i_out_ready && r_i == nm1) |=> (r_cnt == '0 && !r_out_valid))
        else $error("run end did not clear count");
endmodule

// File: rtl/core/rcjv_dp.sv
// Datapath: sample and rank stores, rank counters, sums, influence terms, divider.
// Depends on rcjv_pkg, rcjv_ram, rcjv_div.
module rcjv_dp #(
    parameter int MAX_PAIRS     = rcjv_pkg::MAX_PAIRS_DEF,
    parameter int FRACTION_BITS = rcjv_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rcjv_pkg::t_op                       i_op,
    input  logic [$clog2(MAX_PAIRS)-1:0]        i_raddr,
    input  logic [$clog2(MAX_PAIRS)-1:0]        i_waddr,
    input  logic [$clog2(MAX_PAIRS+1)-1:0]      i_idx,
    input  logic [$clog2(MAX_PAIRS+1)-1:0]      i_n,
    input  logic [rcjv_pkg::DATA_W-1:0]         i_x,
    input  logic [rcjv_pkg::DATA_W-1:0]         i_y,
    output rcjv_pkg::t_sts                      o_sts,
    output logic [rcjv_pkg::IDX_W-1:0]          o_pair_index,
    output logic [rcjv_pkg::DATA_W-1:0]         o_influence,
    output logic [rcjv_pkg::DATA_W-1:0]         o_ratio,
    output logic [rcjv_pkg::DATA_W-1:0]         o_variance,
    output logic                                o_degenerate,
    output logic                                o_last_result
);
    localparam int DW32 = rcjv_pkg::DATA_W;
    localparam int QW   = rcjv_pkg::Q_W;
    localparam int CW   = $clog2(MAX_PAIRS + 1);
    localparam int RW   = CW + 1;
    localparam int PW   = 2 * RW;
    localparam int AW   = PW + CW;
    localparam int SW   = PW;
    localparam int DAW  = PW + 3;
    localparam int DW   = DAW + AW + 1;
    localparam int MW   = DW + CW;
    localparam int SQW  = 2 * DW32 + CW;
    localparam int WW   = rcjv_pkg::maxi(
        rcjv_pkg::maxi(MW + FRACTION_BITS + 1, SQW + 1),
        rcjv_pkg::maxi(2 * AW + QW + 1,
                       rcjv_pkg::maxi(AW + FRACTION_BITS + 1, CW + FRACTION_BITS + QW + 1)));

    function automatic logic [DW32-1:0] sat_s(input logic [QW-1:0] mag, input logic neg);
        logic [DW32-1:0] r;
        if (neg) begin
            r = (mag >= (QW'(1) << (DW32 - 1))) ? {1'b1, {(DW32-1){1'b0}}}
                                                 : DW32'(0) - mag[DW32-1:0];
        end else begin
            r = (mag > QW'({1'b0, {(DW32-1){1'b1}}})) ? {1'b0, {(DW32-1){1'b1}}}
                                                      : mag[DW32-1:0];
        end
        return r;
    endfunction

    logic [DW32-1:0] x_rd, y_rd, inf_rd;
    logic [RW-1:0]   cx_rd, cy_rd;
    logic [RW-1:0]   cx_w, cy_w;
    logic [DW32-1:0] inf_w;

    logic signed [DW32-1:0] r_xi, r_yi;
    logic [CW-1:0]          r_lx, r_ex, r_ly, r_ey;
    logic signed [RW-1:0]   r_cxi, r_cyi;
    logic signed [AW-1:0]   r_a4, r_b4;
    logic signed [SW-1:0]   r_sxr, r_syq, r_syr;
    logic signed [DAW-1:0]  r_da4, r_db4;
    logic signed [DW-1:0]   r_p1, r_p2;
    logic [DW-1:0]          r_mag;
    logic                   r_neg;
    logic [MW-1:0]          r_num;
    logic [2*AW-1:0]        r_den;
    logic                   r_degen;
    logic [DW32-1:0]        r_inf, r_ratio, r_var;
    logic [SQW-1:0]         r_sq;
    logic                   r_rk_acc, r_sum_acc, r_in_acc;
    logic [rcjv_pkg::IDX_W-1:0] r_o_idx;
    logic [DW32-1:0]        r_o_inf;
    logic                   r_o_last;

    logic                   x_lt, x_gt, y_lt, y_gt, x_eq, y_eq;
    logic signed [PW-1:0]   cxcy, cycy, cic, ccc;
    logic signed [SW-1:0]   cy_e, cx_e;
    logic signed [DW-1:0]   p1_w, p2_w, d_w;
    logic [2*AW-1:0]        den_w;
    logic [AW-1:0]          am;
    logic [DW32-1:0]        im;
    logic [2*DW32-1:0]      im2;
    logic                   div_start, div_done;
    logic [WW-1:0]          div_num, div_den;
    logic [QW-1:0]          div_q;

    rcjv_ram #(.W(DW32), .D(MAX_PAIRS)) u_x_ram (
        .i_clk(i_clk), .i_we(i_op == rcjv_pkg::OP_LOAD), .i_waddr(i_waddr),
        .i_wdata(i_x), .i_raddr(i_raddr), .o_rdata(x_rd));
    rcjv_ram #(.W(DW32), .D(MAX_PAIRS)) u_y_ram (
        .i_clk(i_clk), .i_we(i_op == rcjv_pkg::OP_LOAD), .i_waddr(i_waddr),
        .i_wdata(i_y), .i_raddr(i_raddr), .o_rdata(y_rd));
    rcjv_ram #(.W(RW), .D(MAX_PAIRS)) u_cx_ram (
        .i_clk(i_clk), .i_we(i_op == rcjv_pkg::OP_RK_WR), .i_waddr(i_waddr),
        .i_wdata(cx_w), .i_raddr(i_raddr), .o_rdata(cx_rd));
    rcjv_ram #(.W(RW), .D(MAX_PAIRS)) u_cy_ram (
        .i_clk(i_clk), .i_we(i_op == rcjv_pkg::OP_RK_WR), .i_waddr(i_waddr),
        .i_wdata(cy_w), .i_raddr(i_raddr), .o_rdata(cy_rd));
    rcjv_ram #(.W(DW32), .D(MAX_PAIRS)) u_inf_ram (
        .i_clk(i_clk), .i_we(i_op == rcjv_pkg::OP_IN_ST), .i_waddr(i_waddr),
        .i_wdata(inf_w), .i_raddr(i_raddr), .o_rdata(inf_rd));

    rcjv_div #(.W(WW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den), .o_done(div_done), .o_q(div_q));

    always_comb begin
        x_lt = $signed(x_rd) < r_xi;
        x_gt = $signed(x_rd) > r_xi;
        x_eq = !x_lt && !x_gt;
        y_lt = $signed(y_rd) < r_yi;
        y_gt = $signed(y_rd) > r_yi;
        y_eq = !y_lt && !y_gt;
        cx_w = RW'({r_lx, 1'b0}) + RW'(r_ex) - RW'(i_n);
        cy_w = RW'({r_ly, 1'b0}) + RW'(r_ey) - RW'(i_n);
        cxcy = $signed(cx_rd) * $signed(cy_rd);
        cycy = $signed(cy_rd) * $signed(cy_rd);
        cic  = r_cxi * r_cyi;
        ccc  = r_cyi * r_cyi;
        cy_e = SW'($signed(cy_rd));
        cx_e = SW'($signed(cx_rd));
        p1_w = r_da4 * r_b4;
        p2_w = r_a4 * r_db4;
        d_w  = r_p1 - r_p2;
        den_w = $unsigned(r_b4) * $unsigned(r_b4);
        am   = r_a4[AW-1] ? AW'(0) - $unsigned(r_a4) : $unsigned(r_a4);
        im   = r_inf[DW32-1] ? DW32'(0) - r_inf : r_inf;
        im2  = (2*DW32)'(im) * (2*DW32)'(im);
        inf_w = sat_s(div_q, r_neg);
        div_start = 1'b0;
        div_num   = WW'(r_sq);
        div_den   = WW'(i_n) << FRACTION_BITS;
        case (i_op)
            rcjv_pkg::OP_RAT_GO: begin
                div_start = 1'b1;
                div_num   = WW'(am) << FRACTION_BITS;
                div_den   = WW'($unsigned(r_b4));
            end
            rcjv_pkg::OP_IN_GO: begin
                div_start = 1'b1;
                div_num   = WW'(r_num) << FRACTION_BITS;
                div_den   = WW'(r_den);
            end
            rcjv_pkg::OP_VAR_GO: begin
                div_start = 1'b1;
            end
            default: div_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rk_acc  <= 1'b0;
            r_sum_acc <= 1'b0;
            r_in_acc  <= 1'b0;
            r_degen   <= 1'b0;
        end else begin
            r_rk_acc  <= (i_op == rcjv_pkg::OP_RK_ACC);
            r_sum_acc <= (i_op == rcjv_pkg::OP_SUM_ACC);
            r_in_acc  <= (i_op == rcjv_pkg::OP_IN_ACC);
            if (i_op == rcjv_pkg::OP_DEN) begin
                r_degen <= (r_b4 == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rk_acc) begin
            r_lx <= r_lx + CW'(x_lt);
            r_ex <= r_ex + CW'(x_eq);
            r_ly <= r_ly + CW'(y_lt);
            r_ey <= r_ey + CW'(y_eq);
        end
        if (r_sum_acc) begin
            r_a4 <= r_a4 + AW'(cxcy);
            r_b4 <= r_b4 + AW'(cycy);
        end
        if (r_in_acc) begin
            r_sxr <= x_gt ? r_sxr + cy_e : (x_lt ? r_sxr - cy_e : r_sxr);
            r_syq <= y_gt ? r_syq + cx_e : (y_lt ? r_syq - cx_e : r_syq);
            r_syr <= y_gt ? r_syr + cy_e : (y_lt ? r_syr - cy_e : r_syr);
        end
        case (i_op)
            rcjv_pkg::OP_LOAD: begin
                r_a4 <= '0;
                r_b4 <= '0;
                r_sq <= '0;
            end
            rcjv_pkg::OP_RK_LATCH: begin
                r_xi <= $signed(x_rd);
                r_yi <= $signed(y_rd);
                r_lx <= '0;
                r_ex <= '0;
                r_ly <= '0;
                r_ey <= '0;
            end
            rcjv_pkg::OP_DEN:    r_den   <= den_w;
            rcjv_pkg::OP_RAT_ST: r_ratio <= sat_s(div_q, r_a4[AW-1]);
            rcjv_pkg::OP_IN_LATCH: begin
                r_xi  <= $signed(x_rd);
                r_yi  <= $signed(y_rd);
                r_cxi <= $signed(cx_rd);
                r_cyi <= $signed(cy_rd);
                r_sxr <= cy_e;
                r_syq <= cx_e;
                r_syr <= cy_e;
            end
            rcjv_pkg::OP_IN_P1: begin
                r_da4 <= DAW'(cic) + DAW'(r_sxr) + DAW'(r_syq);
                r_db4 <= DAW'(ccc) + (DAW'(r_syr) <<< 1);
            end
            rcjv_pkg::OP_IN_P2: begin
                r_p1 <= p1_w;
                r_p2 <= p2_w;
            end
            rcjv_pkg::OP_IN_P3: begin
                r_neg <= d_w[DW-1];
                r_mag <= d_w[DW-1] ? DW'(0) - $unsigned(d_w) : $unsigned(d_w);
            end
            rcjv_pkg::OP_IN_P4: r_num <= MW'(r_mag) * MW'(i_n);
            rcjv_pkg::OP_IN_ST: r_inf <= inf_w;
            rcjv_pkg::OP_IN_SQ: r_sq  <= r_sq + SQW'(im2);
            rcjv_pkg::OP_VAR_ST: begin
                r_var <= (|div_q[QW-1:DW32]) ? {DW32{1'b1}} : div_q[DW32-1:0];
            end
            rcjv_pkg::OP_OUT_LD: begin
                r_o_idx  <= rcjv_pkg::IDX_W'(i_idx);
                r_o_inf  <= r_degen ? '0 : inf_rd;
                r_o_last <= (i_idx == i_n - CW'(1));
            end
            default: ;
        endcase
    end

    assign o_sts         = '{degen: r_degen, div_done: div_done};
    assign o_pair_index  = r_o_idx;
    assign o_influence   = r_o_inf;
    assign o_ratio       = r_degen ? '0 : r_ratio;
    assign o_variance    = r_degen ? '0 : r_var;
    assign o_degenerate  = r_degen;
    assign o_last_result = r_o_last;
endmodule

// File: rtl/core/rank_correlation_jackknife_variance.sv
// Top level: rank correlation ratio with jackknife influence variance.
// Depends on rcjv_pkg, rcjv_if, rcjv_ctrl, rcjv_dp.
//
//  channel  dir  beat
//  i_in     in   x_sample, y_sample, last_pair
//  o_out    out  pair_index, influence, ratio, variance, degenerate, last_result
//
// Loading takes one beat per cycle; the run starts on the beat with last_pair.
// With n pairs the run makes two n-long sweeps per pair over the single read port of
// the stores, plus a divide per influence and for ratio and variance (skipped when
// degenerate). Each result is read, loaded and then held until the downstream side takes
// it. Input is not taken while a run is busy.
// Synchronous active-low reset clears the controller; no clearing pass.
module rank_correlation_jackknife_variance #(
    parameter int MAX_PAIRS     = rcjv_pkg::MAX_PAIRS_DEF,
    parameter int FRACTION_BITS = rcjv_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rcjv_in_if.sink     i_in,
    rcjv_out_if.source  o_out
);
    localparam int CW  = $clog2(MAX_PAIRS + 1);
    localparam int ADW = $clog2(MAX_PAIRS);

    rcjv_pkg::t_op   op;
    rcjv_pkg::t_sts  sts;
    logic [ADW-1:0]  raddr, waddr;
    logic [CW-1:0]   idx, n;
    logic [rcjv_pkg::DATA_W-1:0] inf_u, ratio_u;

    rcjv_ctrl #(.MAX_PAIRS(MAX_PAIRS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready), .i_last(i_in.last_pair),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .i_sts(sts), .o_op(op), .o_raddr(raddr), .o_waddr(waddr),
        .o_idx(idx), .o_n(n));

    rcjv_dp #(.MAX_PAIRS(MAX_PAIRS), .FRACTION_BITS(FRACTION_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(op),
        .i_raddr(raddr), .i_waddr(waddr), .i_idx(idx), .i_n(n),
        .i_x(i_in.x_sample), .i_y(i_in.y_sample),
        .o_sts(sts), .o_pair_index(o_out.pair_index), .o_influence(inf_u),
        .o_ratio(ratio_u), .o_variance(o_out.variance),
        .o_degenerate(o_out.degenerate), .o_last_result(o_out.last_result));

    assign o_out.influence = $signed(inf_u);
    assign o_out.ratio     = $signed(ratio_u);
endmodule

// File: bench/rank_correlation_jackknife_variance_tb.sv
// Self-checking bench for rank_correlation_jackknife_variance: random and directed sample sets
// with a built-in rank/influence predictor and a per-beat result scoreboard.
// Depends on rcjv_pkg, rcjv_if and the block's RTL.
module rank_correlation_jackknife_variance_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NMAX      = rcjv_pkg::MAX_PAIRS_DEF;
    localparam int FB        = rcjv_pkg::FRAC_BITS_DEF;
    localparam int WD_LIMIT  = 400000;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               last;
        bit                 hold;
        int                 phase;
    } t_pair;

    typedef struct {
        logic [5:0]         idx;
        logic signed [31:0] infl;
        logic signed [31:0] rat;
        logic [31:0]        varq;
        logic               degen;
        logic               last;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rcjv_in_if  in_ch();
    rcjv_out_if out_ch();

    rank_correlation_jackknife_variance dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    t_pair pending[$];
    t_res  expected[$];
    logic signed [31:0] xs[NMAX];
    logic signed [31:0] ys[NMAX];
    int loaded = 0;
    int errors = 0;
    int phase  = 0;
    int idle_cycles = 0;

    function automatic logic [63:0] round_half_up(input logic [127:0] num,
                                                   input logic [127:0] den);
        logic [127:0] twice;
        logic [127:0] q;
        twice = num << 1;
        if (twice >= (den << 34)) return 64'd1 << 33;
        q = twice / den;
        return 64'((q + 1) >> 1);
    endfunction

    function automatic logic signed [31:0] clamp32(input logic [63:0] mag, input bit neg);
        if (neg) return (mag >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(-$signed(mag));
        return (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(mag);
    endfunction

    task automatic predict_set(input int n);
        longint cx[NMAX];
        longint cy[NMAX];
        longint infl[NMAX];
        longint a4, b4, lx, ex, ly, ey, sxr, syq, syr, da4, db4, d;
        logic [127:0] den, sq;
        logic [63:0] mag, im, vq;
        logic signed [31:0] rat;
        t_res r;
        a4 = 0; b4 = 0; sq = 0; rat = 0; vq = 0;
        for (int i = 0; i < n; i++) begin
            lx = 0; ex = 0; ly = 0; ey = 0;
            for (int j = 0; j < n; j++) begin
                if (xs[j] < xs[i]) lx++; else if (xs[j] == xs[i]) ex++;
                if (ys[j] < ys[i]) ly++; else if (ys[j] == ys[i]) ey++;
            end
            cx[i] = 2 * lx + ex - n;
            cy[i] = 2 * ly + ey - n;
        end
        for (int i = 0; i < n; i++) begin
            a4 += cx[i] * cy[i];
            b4 += cy[i] * cy[i];
        end
        if (b4 != 0) begin
            den = 128'(b4) * 128'(b4);
            mag = (a4 < 0) ? 64'(-a4) : 64'(a4);
            rat = clamp32(round_half_up(128'(mag) << FB, 128'(b4)), a4 < 0);
            for (int i = 0; i < n; i++) begin
                sxr = cy[i]; syq = cx[i]; syr = cy[i];
                for (int j = 0; j < n; j++) begin
                    if (xs[j] > xs[i]) sxr += cy[j]; else if (xs[j] < xs[i]) sxr -= cy[j];
                    if (ys[j] > ys[i]) begin
                        syq += cx[j]; syr += cy[j];
                    end else if (ys[j] < ys[i]) begin
                        syq -= cx[j]; syr -= cy[j];
                    end
                end
                da4 = cx[i] * cy[i] + sxr + syq;
                db4 = cy[i] * cy[i] + 2 * syr;
                d = da4 * b4 - a4 * db4;
                mag = (d < 0) ? 64'(-d) : 64'(d);
                infl[i] = clamp32(round_half_up((128'(mag) * 128'(n)) << FB, den), d < 0);
                im = (infl[i] < 0) ? 64'(-infl[i]) : 64'(infl[i]);
                sq += 128'(im) * 128'(im);
            end
            vq = round_half_up(sq, 128'(n) << FB);
            if (vq > 64'hFFFF_FFFF) vq = 64'hFFFF_FFFF;
        end else begin
            for (int i = 0; i < n; i++) infl[i] = 0;
        end
        for (int i = 0; i < n; i++) begin
            r.idx   = 6'(i);
            r.infl  = 32'(infl[i]);
            r.rat   = rat;
            r.varq  = 32'(vq);
            r.degen = (b4 == 0);
            r.last  = (i == n - 1);
            expected.insert(expected.size(), r);
        end
    endtask

    function automatic int idle_pct(input int ph);
        return (ph == 1) ? 78 : (ph == 3) ? 17 : 0;
    endfunction

    function automatic int stall_pct(input int ph);
        return (ph == 2) ? 78 : (ph == 3) ? 17 : 0;
    endfunction

    // driver plus sample capture
    always @(posedge i_clk) begin
        t_pair p;
        bit take;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                if (loaded < NMAX) begin
                    xs[loaded] = in_ch.x_sample;
                    ys[loaded] = in_ch.y_sample;
                    loaded++;
                end
                if (in_ch.last_pair) begin
                    predict_set(loaded);
                    loaded = 0;
                end
            end
            if (!in_ch.valid || in_ch.ready) begin
                take = 0;
                if (pending.size() > 0) begin
                    p = pending[0];
                    take = !(p.hold && expected.size() > 0)
                        && ($urandom_range(99) >= idle_pct(p.phase));
                    phase = p.phase;
                end
                if (take) begin
                    void'(pending.pop_front());
                    in_ch.x_sample  <= p.x;
                    in_ch.y_sample  <= p.y;
                    in_ch.last_pair <= p.last;
                    in_ch.valid     <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and ready driver
    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result beat idx=%0d", out_ch.pair_index);
                end else begin
                    e = expected.pop_front();
                    if (out_ch.pair_index !== e.idx || out_ch.influence !== e.infl
                        || out_ch.ratio !== e.rat || out_ch.variance !== e.varq
                        || out_ch.degenerate !== e.degen || out_ch.last_result !== e.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("result mismatch: exp idx=%0d infl=%0d ratio=%0d var=%0d dg=%b lst=%b got idx=%0d infl=%0d ratio=%0d var=%0d dg=%b lst=%b",
                                e.idx, e.infl, e.rat, e.varq, e.degen, e.last,
                                out_ch.pair_index, out_ch.influence, out_ch.ratio,
                                out_ch.variance, out_ch.degenerate, out_ch.last_result);
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= stall_pct(phase));
        end
    end

    // watchdog on beat progress
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WD_LIMIT) begin
            $display("rank_correlation_jackknife_variance: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_pair(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic last, input bit hold, input int ph);
        t_pair p;
        p.x = x; p.y = y; p.last = last; p.hold = hold; p.phase = ph;
        pending.insert(pending.size(), p);
    endtask

    function automatic logic signed [31:0] rand_sample(input int mode);
        if (mode == 0) return $signed($urandom());
        if (mode == 1) return $signed($urandom_range(6)) - 3;
        return ($urandom_range(1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endfunction

    initial begin
        int count, n, ph, mx, my, set_no;
        bit hold;
        in_ch.valid = 1'b0;
        in_ch.x_sample = '0;
        in_ch.y_sample = '0;
        in_ch.last_pair = 1'b0;
        out_ch.ready = 1'b0;

        // single pair: degenerate
        add_pair(32'sd5, -32'sd7, 1'b1, 1'b0, 0);
        // y all equal: degenerate
        add_pair(32'sd1, 32'sd9, 1'b0, 1'b0, 0);
        add_pair(32'sd2, 32'sd9, 1'b0, 1'b0, 0);
        add_pair(32'sd3, 32'sd9, 1'b1, 1'b0, 0);
        // extremes with ties
        add_pair(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 1'b1, 0);
        add_pair(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 1'b0, 0);
        add_pair(32'sd0,         -32'sd1,        1'b0, 1'b0, 0);
        add_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 1'b0, 0);
        add_pair(-32'sd1,        32'sd0,         1'b1, 1'b0, 0);
        // perfect order, reverse order, then a set with ties on both sides
        for (int i = 0; i < 4; i++) add_pair(i, i, i == 3, 1'b0, 0);
        for (int i = 0; i < 4; i++) add_pair(i, -i, i == 3, 1'b0, 0);
        for (int i = 0; i < 5; i++) add_pair(i / 2, i % 2, i == 4, 1'b0, 0);

        count = 0;
        set_no = 0;
        while (count < 260) begin
            ph = set_no % 4;
            hold = (set_no % 7 == 3);
            if (set_no == 9) n = NMAX + 3;
            else if ($urandom_range(9) == 0) n = $urandom_range(24, 9);
            else n = $urandom_range(8, 1);
            mx = $urandom_range(2);
            my = $urandom_range(2);
            for (int i = 0; i < n; i++)
                add_pair(rand_sample(mx), rand_sample(my), i == n - 1, hold && i == 0, ph);
            count += n;
            set_no++;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() > 0 || in_ch.valid || expected.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("rank_correlation_jackknife_variance: match");
        end else begin
            $display("rank_correlation_jackknife_variance: mismatch");
        end
        $finish;
    end
endmodule
